// ----- hw/rtl/rbnh_pkg.sv -----
package rbnh_pkg;

    localparam int COORD_W           = 32;
    localparam int INDEX_W           = 6;
    localparam int COUNT_W           = 7;
    localparam int MAX_BOXES_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 16;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_TEST,
        S_FINISH
    } state_t;

    typedef struct packed
    {
        op_t                        operation;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [COORD_W-1:0]  box_min_x;
        logic signed [COORD_W-1:0]  box_min_y;
        logic signed [COORD_W-1:0]  box_max_x;
        logic signed [COORD_W-1:0]  box_max_y;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  dir_x;
        logic signed [COORD_W-1:0]  dir_y;
        logic signed [COORD_W-1:0]  max_distance;
    } req_t;

    typedef struct packed
    {
        logic                       hit;
        logic [INDEX_W-1:0]         hit_index;
        logic signed [COORD_W-1:0]  hit_distance;
    } rsp_t;

endpackage

// ----- hw/rtl/rbnh_box_store.sv -----
module rbnh_box_store #(
    parameter int DEPTH = rbnh_pkg::MAX_BOXES_DEF,
    parameter int IDX_W = 6
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [2*rbnh_pkg::COORD_W-1:0] wr_low,
    input  logic [2*rbnh_pkg::COORD_W-1:0] wr_high,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [2*rbnh_pkg::COORD_W-1:0] rd_low,
    output logic [2*rbnh_pkg::COORD_W-1:0] rd_high
);
    import rbnh_pkg::*;

    logic [2*COORD_W-1:0] low_mem  [DEPTH];
    logic [2*COORD_W-1:0] high_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            low_mem[wr_addr]  <= wr_low;
            high_mem[wr_addr] <= wr_high;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_low  <= low_mem[rd_addr];
            rd_high <= high_mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/rbnh_slab_div.sv -----
module rbnh_slab_div #(
    parameter int FRAC_W = rbnh_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [rbnh_pkg::COORD_W-1:0] corner,
    input  logic signed [rbnh_pkg::COORD_W-1:0] origin,
    input  logic signed [rbnh_pkg::COORD_W-1:0] dir,
    output logic                                done,
    output logic signed [rbnh_pkg::COORD_W-1:0] t
);
    import rbnh_pkg::*;

    localparam int DW = COORD_W + 1 + FRAC_W;
    localparam int CW = $clog2(DW + 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [DW-1:0]           q_reg;
    logic [COORD_W-1:0]      rem_reg;
    logic [COORD_W-1:0]      den_reg;
    logic                    neg_reg;

    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [COORD_W:0]        rem_sh;
    logic                    ge;
    logic                    pos_ovf;
    logic                    neg_ovf;

    assign diff   = {corner[COORD_W-1], corner} - {origin[COORD_W-1], origin};
    assign mag    = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
    assign rem_sh = {rem_reg, q_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division on magnitudes, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {mag, {FRAC_W{1'b0}}};
            rem_reg <= '0;
            den_reg <= dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
            neg_reg <= diff[COORD_W] ^ dir[COORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? COORD_W'(rem_sh - {1'b0, den_reg}) : rem_sh[COORD_W-1:0];
            q_reg   <= {q_reg[DW-2:0], ge};
        end
    end

    // saturate to the signed 32-bit range
    assign pos_ovf = |q_reg[DW-1:COORD_W-1];
    assign neg_ovf = (|q_reg[DW-1:COORD_W])
                     || (q_reg[COORD_W-1] && (|q_reg[COORD_W-2:0]));

    always_comb
    begin
        if (neg_reg)
            t = neg_ovf ? {1'b1, {(COORD_W-1){1'b0}}} : -$signed(q_reg[COORD_W-1:0]);
        else
            t = pos_ovf ? {1'b0, {(COORD_W-1){1'b1}}} : $signed(q_reg[COORD_W-1:0]);
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/ray_box_nearest_hit_unit.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  rbnh_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  rbnh_pkg::rsp_t
// box_count in         box_count_we           box_count_data
//
// A write request is taken in the idle state. A cast handles the n boxes in use
// (t in Q16.16 at the default FRACTION_BITS) with the four radix-2 slab dividers
// that run side by side, one box at a time from the box store.
// Reset clears control state and box_count; the store holds garbage until written.
// rsp_stall holds the finished result in its register; a new request is still
// taken, and the next cast waits at its end until the register is free.
module ray_box_nearest_hit_unit #(
    parameter int MAX_BOXES     = rbnh_pkg::MAX_BOXES_DEF,
    parameter int FRACTION_BITS = rbnh_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  rbnh_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output rbnh_pkg::rsp_t                rsp,
    input  logic                          box_count_we,
    input  logic [rbnh_pkg::COUNT_W-1:0]  box_count_data
);
    import rbnh_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [COUNT_W-1:0]       box_count_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         n_calc;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_plus;
    logic signed [COORD_W-1:0] ox_reg;
    logic signed [COORD_W-1:0] oy_reg;
    logic signed [COORD_W-1:0] dx_reg;
    logic signed [COORD_W-1:0] dy_reg;
    logic signed [COORD_W-1:0] best_reg;
    logic [INDEX_W-1:0]       best_idx_reg;
    logic                     hit_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;

    logic                     accept;
    logic                     last;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     div_start;
    logic [2*COORD_W-1:0]     rd_low;
    logic [2*COORD_W-1:0]     rd_high;
    logic [3:0]               div_done;
    logic signed [COORD_W-1:0] t_lx;
    logic signed [COORD_W-1:0] t_hx;
    logic signed [COORD_W-1:0] t_ly;
    logic signed [COORD_W-1:0] t_hy;
    logic signed [COORD_W-1:0] tx_lo;
    logic signed [COORD_W-1:0] tx_hi;
    logic signed [COORD_W-1:0] ty_lo;
    logic signed [COORD_W-1:0] ty_hi;
    logic signed [COORD_W-1:0] tmin;
    logic signed [COORD_W-1:0] tmax;
    logic                     good;
    logic                     rsp_free;

    assign accept   = req_valid && !req_stall;
    assign idx_plus = idx_reg + 1'b1;
    assign last     = (idx_plus == n_reg);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (32'(box_count_reg) > 32'(MAX_BOXES))
            n_calc = CNT_W'(MAX_BOXES);
        else
            n_calc = CNT_W'(box_count_reg);
    end

    rbnh_box_store #(
        .DEPTH (MAX_BOXES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && (req.operation == OP_WRITE)
                  && (32'(req.entry_index) < 32'(MAX_BOXES))),
        .wr_addr (IDX_W'(req.entry_index)),
        .wr_low  ({req.box_min_y, req.box_min_x}),
        .wr_high ({req.box_max_y, req.box_max_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_low  (rd_low),
        .rd_high (rd_high)
    );

    rbnh_slab_div #(.FRAC_W(FRACTION_BITS)) u_div_lx (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .corner (rd_low[COORD_W-1:0]), .origin (ox_reg), .dir (dx_reg),
        .done (div_done[0]), .t (t_lx)
    );

    rbnh_slab_div #(.FRAC_W(FRACTION_BITS)) u_div_hx (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .corner (rd_high[COORD_W-1:0]), .origin (ox_reg), .dir (dx_reg),
        .done (div_done[1]), .t (t_hx)
    );

    rbnh_slab_div #(.FRAC_W(FRACTION_BITS)) u_div_ly (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .corner (rd_low[2*COORD_W-1:COORD_W]), .origin (oy_reg), .dir (dy_reg),
        .done (div_done[2]), .t (t_ly)
    );

    rbnh_slab_div #(.FRAC_W(FRACTION_BITS)) u_div_hy (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .corner (rd_high[2*COORD_W-1:COORD_W]), .origin (oy_reg), .dir (dy_reg),
        .done (div_done[3]), .t (t_hy)
    );

    assign tx_lo = (t_lx < t_hx) ? t_lx : t_hx;
    assign tx_hi = (t_lx > t_hx) ? t_lx : t_hx;
    assign ty_lo = (t_ly < t_hy) ? t_ly : t_hy;
    assign ty_hi = (t_ly > t_hy) ? t_ly : t_hy;
    assign tmin  = (tx_lo > ty_lo) ? tx_lo : ty_lo;
    assign tmax  = (tx_hi < ty_hi) ? tx_hi : ty_hi;
    assign good  = !tmax[COORD_W-1] && (tmin <= tmax) && (tmin < best_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.operation == OP_CAST))
                    state_next = (n_calc == '0) ? S_FINISH : S_LOAD;
            end
            S_LOAD:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_done[0])
                    state_next = S_TEST;
            end
            S_TEST:   state_next = last ? S_FINISH : S_LOAD;
            S_FINISH:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        rd_addr   = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                rd_en     = accept && (req.operation == OP_CAST);
            end
            S_LOAD:   div_start = 1'b1;
            S_DIV:    ;
            S_TEST:
            begin
                rd_en   = !last;
                rd_addr = IDX_W'(idx_plus);
            end
            S_FINISH: ;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            best_idx_reg  <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (box_count_we)
                box_count_reg <= box_count_data;
            if ((state_reg == S_FINISH) && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req.operation == OP_CAST))
                    begin
                        hit_reg      <= 1'b0;
                        best_idx_reg <= '0;
                        idx_reg      <= '0;
                        n_reg        <= n_calc;
                    end
                end
                S_TEST:
                begin
                    if (good)
                    begin
                        hit_reg      <= 1'b1;
                        best_idx_reg <= INDEX_W'(idx_reg);
                    end
                    idx_reg <= idx_plus;
                end
                S_LOAD, S_DIV, S_FINISH: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && accept && (req.operation == OP_CAST))
        begin
            ox_reg   <= req.origin_x;
            oy_reg   <= req.origin_y;
            dx_reg   <= (req.dir_x == '0) ? COORD_W'(1) : req.dir_x;
            dy_reg   <= (req.dir_y == '0) ? COORD_W'(1) : req.dir_y;
            best_reg <= req.max_distance;
        end
        else if ((state_reg == S_TEST) && good)
        begin
            best_reg <= tmin;
        end
        if ((state_reg == S_FINISH) && rsp_free)
        begin
            rsp_reg.hit          <= hit_reg;
            rsp_reg.hit_index    <= best_idx_reg;
            rsp_reg.hit_distance <= best_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // all four slab dividers run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_done == 4'b0000) || (div_done == 4'b1111))
        else $error("slab dividers out of step");

    // a box is only fetched while inside the count in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (idx_reg < n_reg))
        else $error("box index beyond count");

    // a result appears only from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result without finished cast");

    // no hit keeps the index at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !hit_reg |-> (best_idx_reg == '0))
        else $error("index set without hit");

    // dividers finish only while waiting on them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (state_reg == S_DIV))
        else $error("divider done outside wait");

endmodule

// ----- test/ray_box_nearest_hit_unit_tb.sv -----
`timescale 1ns / 1ps

module ray_box_nearest_hit_unit_tb;

    import rbnh_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 40;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                req_valid      = 1'b0;
    logic                req_stall;
    req_t                req            = '0;
    logic                rsp_valid;
    logic                rsp_stall      = 1'b0;
    rsp_t                rsp;
    logic                box_count_we   = 1'b0;
    logic [COUNT_W-1:0]  box_count_data = '0;

    ray_box_nearest_hit_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .box_count_we   (box_count_we),
        .box_count_data (box_count_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Own copy of the box store and the count register
    logic signed [31:0] shadow_min_x [NUM_ENTRIES];
    logic signed [31:0] shadow_min_y [NUM_ENTRIES];
    logic signed [31:0] shadow_max_x [NUM_ENTRIES];
    logic signed [31:0] shadow_max_y [NUM_ENTRIES];
    int                 boxes_in_use = 0;

    req_t pending_requests [$];
    rsp_t expected_hits    [$];
    int   error_count = 0;
    int   idle_cycles = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic longint slab_param(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic rsp_t nearest_hit(req_t r);
        rsp_t   res;
        longint ox, oy, dx, dy, best;
        longint tx1, tx2, ty1, ty2, tmin, tmax;
        int     n;
        int     best_idx;
        logic   found;
        ox = r.origin_x;
        oy = r.origin_y;
        dx = (r.dir_x == 0) ? 1 : r.dir_x;
        dy = (r.dir_y == 0) ? 1 : r.dir_y;
        best = r.max_distance;
        best_idx = 0;
        found = 1'b0;
        n = (boxes_in_use > NUM_ENTRIES) ? NUM_ENTRIES : boxes_in_use;
        for (int i = 0; i < n; i++)
        begin
            tx1 = slab_param(longint'(shadow_min_x[i]) - ox, dx);
            tx2 = slab_param(longint'(shadow_max_x[i]) - ox, dx);
            ty1 = slab_param(longint'(shadow_min_y[i]) - oy, dy);
            ty2 = slab_param(longint'(shadow_max_y[i]) - oy, dy);
            tmin = ((tx1 < tx2) ? tx1 : tx2) > ((ty1 < ty2) ? ty1 : ty2) ?
                   ((tx1 < tx2) ? tx1 : tx2) : ((ty1 < ty2) ? ty1 : ty2);
            tmax = ((tx1 > tx2) ? tx1 : tx2) < ((ty1 > ty2) ? ty1 : ty2) ?
                   ((tx1 > tx2) ? tx1 : tx2) : ((ty1 > ty2) ? ty1 : ty2);
            if (tmax >= 0 && tmin <= tmax && tmin < best)
            begin
                best = tmin;
                best_idx = i;
                found = 1'b1;
            end
        end
        res.hit          = found;
        res.hit_index    = found ? best_idx[INDEX_W-1:0] : '0;
        res.hit_distance = best[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 400 << 16)) - (200 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_dir();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_ffff;
            3:       return $urandom;
            4:       return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_reach();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return $urandom;
            default: return $urandom_range(0, 2000 << 16);
        endcase
    endfunction

    task automatic push_write(input int idx, input logic signed [31:0] lx,
                              input logic signed [31:0] ly, input logic signed [31:0] hx,
                              input logic signed [31:0] hy);
        req_t r;
        r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
        r.operation   = OP_WRITE;
        r.entry_index = idx[INDEX_W-1:0];
        r.box_min_x   = lx;
        r.box_min_y   = ly;
        r.box_max_x   = hx;
        r.box_max_y   = hy;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic push_cast(input logic signed [31:0] ox, input logic signed [31:0] oy,
                             input logic signed [31:0] dx, input logic signed [31:0] dy,
                             input logic signed [31:0] reach);
        req_t r;
        r = $bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
        r.operation    = OP_CAST;
        r.origin_x     = ox;
        r.origin_y     = oy;
        r.dir_x        = dx;
        r.dir_y        = dy;
        r.max_distance = reach;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic push_random_box(input int idx);
        logic signed [31:0] lx, ly;
        if ($urandom_range(0, 9) < 7)
        begin
            lx = $signed($urandom_range(0, 300 << 16)) - (150 << 16);
            ly = $signed($urandom_range(0, 300 << 16)) - (150 << 16);
            push_write(idx, lx, ly, lx + $urandom_range(0, 60 << 16),
                       ly + $urandom_range(0, 60 << 16));
        end
        else
            push_write(idx, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    // Sample at the falling edge so the driver's updates have settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_hits.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_box_count(input int value);
        box_count_we   <= 1'b1;
        box_count_data <= value[COUNT_W-1:0];
        @(posedge clk);
        box_count_we   <= 1'b0;
        boxes_in_use = value;
    endtask

    // Driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                if (req.operation == OP_WRITE)
                begin
                    shadow_min_x[req.entry_index] = req.box_min_x;
                    shadow_min_y[req.entry_index] = req.box_min_y;
                    shadow_max_x[req.entry_index] = req.box_max_x;
                    shadow_max_y[req.entry_index] = req.box_max_y;
                end
                else
                    expected_hits.insert(expected_hits.size(), nearest_hit(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req       <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: check responses, stall on a pattern, watch for hangs
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected response", rsp.hit_distance, 0);
                else
                begin
                    want = expected_hits.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", rsp.hit, want.hit);
                    if (rsp.hit_index !== want.hit_index)
                        report_mismatch("hit_index", rsp.hit_index, want.hit_index);
                    if (rsp.hit_distance !== want.hit_distance)
                        report_mismatch("hit_distance", rsp.hit_distance, want.hit_distance);
                end
            end
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(10, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= $urandom_range(0, 1);
                default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial
    begin
        int count;
        int n_items;
        int total;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole store before any entry is read; casts with no boxes in use
        for (int i = 0; i < NUM_ENTRIES; i++)
            push_random_box(i);
        push_cast(0, 0, 1 << 16, 1 << 16, 32'sh7fff_ffff);
        push_cast(32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000);
        drain();

        // Directed: tie between identical boxes, inverted box, extreme corners
        set_box_count(4);
        push_write(0, 10 << 16, -(5 << 16), 20 << 16, 5 << 16);
        push_write(1, 10 << 16, -(5 << 16), 20 << 16, 5 << 16);
        push_write(2, 8 << 16, 6 << 16, 4 << 16, -(6 << 16));
        push_write(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        push_cast(0, 0, 1 << 16, 0, 32'sh7fff_ffff);
        push_cast(0, 0, 1 << 16, 0, 5 << 16);
        push_cast(30 << 16, 0, -(1 << 16), 0, 32'sh7fff_ffff);
        push_cast(0, 0, 0, 0, 32'sh7fff_ffff);
        push_cast(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff);
        push_cast(32'sh8000_0000, 32'sh8000_0000, 1, 1, 32'sh7fff_ffff);
        push_cast(0, 0, 32'sh7fff_ffff, -1, 0);
        push_cast(100 << 16, 100 << 16, 1 << 16, 1 << 16, 32'sh8000_0000);
        push_write(3, 50 << 16, 50 << 16, 60 << 16, 60 << 16);
        push_cast(0, 0, 1 << 16, 1 << 16, 32'sh7fff_ffff);
        drain();

        // Random phases over several box counts, the extremes included
        total = 0;
        for (int phase = 0; total < 520; phase++)
        begin
            case (phase)
                0:       count = 64;
                1:       count = 127;
                2:       count = 0;
                3:       count = 1;
                default: count = $urandom_range(1, 8);
            endcase
            set_box_count(count);
            n_items = (count > 16) ? 6 : 40;
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 9) < 3)
                    push_random_box($urandom_range(0, NUM_ENTRIES - 1));
                else
                    push_cast(pick_coord(), pick_coord(), pick_dir(), pick_dir(), pick_reach());
            end
            total += n_items;
            drain();
        end

        if (expected_hits.size() != 0)
            report_mismatch("responses missing", 0, expected_hits.size());
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- ray_box_nearest_hit_unit.f -----
hw/rtl/rbnh_pkg.sv
hw/rtl/rbnh_box_store.sv
hw/rtl/rbnh_slab_div.sv
hw/rtl/ray_box_nearest_hit_unit.sv
test/ray_box_nearest_hit_unit_tb.sv
